// File: design/tmrle_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// tmrle_pkg
// Shared types and constants for the tile map run-length decoder.
// ============================================================================
package tmrle_pkg;

    // Code byte layout
    localparam int CODE_W      = 8;
    localparam int SKIP_W      = 7;   // skip count, bits 6..0
    localparam int RUN_W       = 6;   // run length, bits 5..0
    localparam int SOLID_BIT   = 7;
    localparam int VERT_BIT    = 6;

    // Result coordinate fields
    localparam int COORD_W     = 5;

    // Stream payload widths
    localparam int S_DATA_W    = 8;
    localparam int M_DATA_W    = 16;

    // Sequencer states, one-hot
    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_DECODE = 6'b000010,
        ST_NORM   = 6'b000100,
        ST_READ   = 6'b001000,
        ST_CHECK  = 6'b010000,
        ST_FLUSH  = 6'b100000
    } state_t;

endpackage

// File: design/tmrle_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// tmrle_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module tmrle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 24
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, holds when not reading
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: design/tile_map_rle_decoder_core.sv
`timescale 1ns / 1ps
// ============================================================================
// tile_map_rle_decoder_core
// Run-length decoder for a solid-tile map, reporting each newly solid tile.
// ============================================================================
// One code byte is taken per request; the block then stays busy until the
// byte is fully applied. A zero byte goes from decode straight back to idle.
// A skip byte adds its count to the column, then the cursor is renormalized
// by a single compare-and-subtract unit that removes one row width a cycle.
// A run byte walks up to 63 tiles by read-modify-write of the row RAM: the
// read state reads the row, and the check state tests and sets the bit. A
// run of length zero, or any run while the cursor sits at the end of the
// map, returns to idle from decode. Output backpressure can hold the
// check and flush states. Each new tile leaves as one result on the master
// side; tlast marks the last result of a byte, and a byte that sets no new
// tile produces no result. The map is cleared without a sweep: per-row
// valid flags are dropped at reset and on a start request, so the block is
// ready right after reset.
module tile_map_rle_decoder_core #(
    parameter int MAP_COLUMNS = 32,
    parameter int MAP_ROWS    = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    // Input requests
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] code_byte
    input  logic        s_axis_tuser,   // [0] start_level
    // Tile results
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [4:0] tile_x, [9:5] tile_y, zero fill
    output logic        m_axis_tlast    // last_in_run
);

    localparam int COL_W = $clog2(MAP_COLUMNS);
    localparam int RA_W  = $clog2(MAP_ROWS);
    localparam int ROW_W = $clog2(MAP_ROWS + 1);
    localparam int CX_W  = ((COL_W > tmrle_pkg::SKIP_W) ? COL_W : tmrle_pkg::SKIP_W) + 1;

    tmrle_pkg::state_t state_reg, state_next;

    logic [COL_W-1:0]            col_reg, col_next;
    logic [ROW_W-1:0]            row_reg, row_next;
    logic [ROW_W-1:0]            vrow_reg, vrow_next;
    logic [CX_W-1:0]             cx_reg, cx_next;
    logic [tmrle_pkg::RUN_W-1:0] cnt_reg, cnt_next;
    logic                        vert_reg, vert_next;
    logic [tmrle_pkg::CODE_W-1:0] code_reg, code_next;
    logic [MAP_ROWS-1:0]         valid_reg, valid_next;

    logic                        pend_valid_reg, pend_valid_next;
    logic [COL_W-1:0]            pend_x_reg, pend_x_next;
    logic [ROW_W-1:0]            pend_y_reg, pend_y_next;

    logic                           out_valid_reg, out_valid_next;
    logic [tmrle_pkg::COORD_W-1:0]  out_x_reg, out_x_next;
    logic [tmrle_pkg::COORD_W-1:0]  out_y_reg, out_y_next;
    logic                           out_last_reg, out_last_next;

    // Target tile and row RAM signals
    logic [COL_W-1:0]    tx;
    logic [ROW_W-1:0]    ty;
    logic [RA_W-1:0]     ty_addr;
    logic [MAP_COLUMNS-1:0] row_q;
    logic [MAP_COLUMNS-1:0] row_word;
    logic [MAP_COLUMNS-1:0] row_wdata;
    logic                ram_we;
    logic                ram_re;
    logic                tile_set;
    logic                out_free;
    logic                accept;

    assign tx      = col_reg;
    assign ty      = vert_reg ? vrow_reg : row_reg;
    assign ty_addr = ty[RA_W-1:0];

    // Row word as stored, invalid rows read as clear
    assign row_word  = valid_reg[ty_addr] ? row_q : '0;
    assign tile_set  = row_word[tx];
    assign row_wdata = row_word | (MAP_COLUMNS'(1) << tx);

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == tmrle_pkg::ST_IDLE);

    tmrle_ram #(
        .WIDTH (MAP_COLUMNS),
        .DEPTH (MAP_ROWS)
    ) u_row_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ty_addr),
        .wdata (row_wdata),
        .re    (ram_re),
        .raddr (ty_addr),
        .rdata (row_q)
    );

    // Sequencer
    always_comb
    begin
        logic step_done;
        logic at_last_col;
        logic at_last_tile;

        state_next      = state_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        vrow_next       = vrow_reg;
        cx_next         = cx_reg;
        cnt_next        = cnt_reg;
        vert_next       = vert_reg;
        code_next       = code_reg;
        valid_next      = valid_reg;
        pend_valid_next = pend_valid_reg;
        pend_x_next     = pend_x_reg;
        pend_y_next     = pend_y_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_x_next      = out_x_reg;
        out_y_next      = out_y_reg;
        out_last_next   = out_last_reg;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        step_done       = 1'b0;

        at_last_col  = (col_reg == COL_W'(MAP_COLUMNS - 1));
        at_last_tile = at_last_col && (row_reg == ROW_W'(MAP_ROWS - 1));

        case (state_reg)
            tmrle_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    code_next = s_axis_tdata;
                    if (s_axis_tuser)
                    begin
                        valid_next = '0;
                        col_next   = '0;
                        row_next   = '0;
                    end
                    state_next = tmrle_pkg::ST_DECODE;
                end
            end

            tmrle_pkg::ST_DECODE:
            begin
                vert_next = code_reg[tmrle_pkg::VERT_BIT];
                vrow_next = row_reg;
                cnt_next  = code_reg[tmrle_pkg::RUN_W-1:0];
                if (code_reg == '0)
                begin
                    state_next = tmrle_pkg::ST_IDLE;
                end
                else if (!code_reg[tmrle_pkg::SOLID_BIT])
                begin
                    // skip: add count to column, then fold rows out
                    cx_next    = CX_W'(col_reg) + CX_W'(code_reg[tmrle_pkg::SKIP_W-1:0]);
                    state_next = tmrle_pkg::ST_NORM;
                end
                else if (row_reg == ROW_W'(MAP_ROWS))
                begin
                    // cursor saturated, nothing to mark
                    state_next = tmrle_pkg::ST_IDLE;
                end
                else if (code_reg[tmrle_pkg::RUN_W-1:0] == '0)
                begin
                    // empty run; a vertical one still moves on by one
                    if (code_reg[tmrle_pkg::VERT_BIT])
                    begin
                        if (at_last_col)
                        begin
                            col_next = '0;
                            row_next = row_reg + 1'b1;
                        end
                        else
                        begin
                            col_next = col_reg + 1'b1;
                        end
                    end
                    state_next = tmrle_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = tmrle_pkg::ST_READ;
                end
            end

            tmrle_pkg::ST_NORM:
            begin
                if ((row_reg != ROW_W'(MAP_ROWS)) && (cx_reg >= CX_W'(MAP_COLUMNS)))
                begin
                    cx_next  = cx_reg - CX_W'(MAP_COLUMNS);
                    row_next = row_reg + 1'b1;
                end
                else
                begin
                    col_next   = (row_reg == ROW_W'(MAP_ROWS)) ? '0 : cx_reg[COL_W-1:0];
                    state_next = tmrle_pkg::ST_IDLE;
                end
            end

            tmrle_pkg::ST_READ:
            begin
                ram_re     = 1'b1;
                state_next = tmrle_pkg::ST_CHECK;
            end

            tmrle_pkg::ST_CHECK:
            begin
                if (!tile_set && pend_valid_reg && !out_free)
                begin
                    // result slot full, hold this tile
                    state_next = tmrle_pkg::ST_CHECK;
                end
                else
                begin
                    if (!tile_set)
                    begin
                        ram_we               = 1'b1;
                        valid_next[ty_addr]  = 1'b1;
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_x_next     = tmrle_pkg::COORD_W'(pend_x_reg);
                            out_y_next     = tmrle_pkg::COORD_W'(pend_y_reg);
                            out_last_next  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_x_next     = tx;
                        pend_y_next     = ty;
                    end
                    cnt_next = cnt_reg - 1'b1;
                    if (vert_reg)
                    begin
                        vrow_next = vrow_reg + 1'b1;
                        step_done = (cnt_reg == tmrle_pkg::RUN_W'(1))
                                 || (vrow_reg == ROW_W'(MAP_ROWS - 1));
                        if (step_done)
                        begin
                            if (at_last_col)
                            begin
                                col_next = '0;
                                row_next = row_reg + 1'b1;
                            end
                            else
                            begin
                                col_next = col_reg + 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        step_done = (cnt_reg == tmrle_pkg::RUN_W'(1)) || at_last_tile;
                        if (at_last_col)
                        begin
                            col_next = '0;
                            row_next = row_reg + 1'b1;
                        end
                        else
                        begin
                            col_next = col_reg + 1'b1;
                        end
                    end
                    state_next = step_done ? tmrle_pkg::ST_FLUSH : tmrle_pkg::ST_READ;
                end
            end

            tmrle_pkg::ST_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = tmrle_pkg::ST_IDLE;
                end
                else if (out_free)
                begin
                    // final result of this byte
                    out_valid_next  = 1'b1;
                    out_x_next      = tmrle_pkg::COORD_W'(pend_x_reg);
                    out_y_next      = tmrle_pkg::COORD_W'(pend_y_reg);
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = tmrle_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = tmrle_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= tmrle_pkg::ST_IDLE;
            col_reg        <= '0;
            row_reg        <= '0;
            valid_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            valid_reg      <= valid_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload and working registers
    always_ff @(posedge clk)
    begin
        vrow_reg     <= vrow_next;
        cx_reg       <= cx_next;
        cnt_reg      <= cnt_next;
        vert_reg     <= vert_next;
        code_reg     <= code_next;
        pend_x_reg   <= pend_x_next;
        pend_y_reg   <= pend_y_next;
        out_x_reg    <= out_x_next;
        out_y_reg    <= out_y_next;
        out_last_reg <= out_last_next;
    end

    // Result port
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {6'b0, out_y_reg, out_x_reg};

endmodule

// File: design/tmrle_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// tmrle_checker
// Port-level checks for the tile map run-length decoder, bound to the top.
// ============================================================================
module tmrle_checker #(
    parameter int MAP_COLUMNS = 32,
    parameter int MAP_ROWS    = 24
) (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // Stalled result holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

    // A byte is still being worked on in the cycle after its request is accepted
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("ready right after accepting a byte");

    // A non-final result means its byte is still in progress
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
    else $error("ready while a byte still has results to send");

    // Reported tile lies on the map
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (MAP_ROWS > 32 || m_axis_tdata[9:5] < MAP_ROWS)
                       && (MAP_COLUMNS > 32 || m_axis_tdata[4:0] < MAP_COLUMNS))
    else $error("reported tile outside the map");

endmodule

bind tile_map_rle_decoder_core tmrle_checker #(
    .MAP_COLUMNS (MAP_COLUMNS),
    .MAP_ROWS    (MAP_ROWS)
) u_tmrle_checker (.*);

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Self-checking bench for the tile map run-length decoder core.
// ============================================================================
// Code bytes are queued by a stimulus block and pushed by a clocked driver
// with random gaps. Each accepted request is run through a local model of the
// tile map and cursor, which queues the tiles it should report. A clocked
// monitor pulls results under random backpressure and compares x, y, tlast
// and the zero fill against the oldest queued tile. A directed set covers
// every code kind, the field extremes, wrapping, clipping, already-solid
// tiles and the saturated cursor. Random map levels follow.
// ============================================================================
module tb_top;

    localparam int COLS       = 32;
    localparam int ROWS       = 24;
    localparam int TILE_COUNT = COLS * ROWS;
    localparam int RANDOM_CODES = 360;
    localparam int HOLD_AFTER   = 120;   // requests accepted before the long stall
    localparam int HOLD_CYCLES  = 400;
    localparam int TAIL_CYCLES  = 300;
    localparam int PRINT_LIMIT  = 50;

    // One expected tile result
    typedef struct packed {
        logic [tmrle_pkg::COORD_W-1:0] x;
        logic [tmrle_pkg::COORD_W-1:0] y;
        logic                          last;
    } tile_t;

    // One queued code byte; drain holds it back until all tiles are out
    typedef struct {
        logic [tmrle_pkg::CODE_W-1:0] code;
        logic                         start;
        bit                           drain;
    } code_req_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tlast;

    // Local map model
    bit [COLS-1:0] solid_rows [ROWS];
    int unsigned   cursor;

    code_req_t   pending_codes [$];
    tile_t       tile_expect [$];
    code_req_t   next_req;
    tile_t       want_tile;
    logic        offer;
    int          send_gap;
    int          ready_gap;
    int          codes_sent;
    int          tiles_seen;
    int          map_clears;
    int          mismatch_count;
    int          cycle_count;
    int          hold_left;
    bit          hold_done;

    tile_map_rle_decoder_core #(
        .MAP_COLUMNS(COLS),
        .MAP_ROWS(ROWS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast)
    );

    // Clock, 2 ns period
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_LIMIT)
            $display("[%0t] mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    // Set one tile; queue a result only if it was clear
    function automatic void claim_tile(input int unsigned col, input int unsigned row);
        tile_t t;
        if (!solid_rows[row][col])
        begin
            solid_rows[row][col] = 1'b1;
            t.x = col[tmrle_pkg::COORD_W-1:0];
            t.y = row[tmrle_pkg::COORD_W-1:0];
            t.last = 1'b0;
            tile_expect = {tile_expect, t};
        end
    endfunction

    // Apply one code byte to the map model and queue the tiles it sets
    task automatic apply_code(input logic [tmrle_pkg::CODE_W-1:0] code, input logic start);
        int unsigned run_len;
        int unsigned col;
        int unsigned row;
        int unsigned k;
        int          queued_before;
        tile_t       t;
        queued_before = tile_expect.size();
        if (start)
        begin
            foreach (solid_rows[r])
                solid_rows[r] = '0;
            cursor = 0;
            map_clears++;
        end
        run_len = code[tmrle_pkg::RUN_W-1:0];
        if (code == '0)
        begin
            // ignored
        end
        else if (!code[tmrle_pkg::SOLID_BIT])
        begin
            cursor = cursor + code[tmrle_pkg::SKIP_W-1:0];
            if (cursor > TILE_COUNT)
                cursor = TILE_COUNT;
        end
        else if (!code[tmrle_pkg::VERT_BIT])
        begin
            for (k = 0; k < run_len && cursor < TILE_COUNT; k++)
            begin
                claim_tile(cursor % COLS, cursor / COLS);
                cursor++;
            end
        end
        else if (cursor < TILE_COUNT)
        begin
            col = cursor % COLS;
            row = cursor / COLS;
            for (k = 0; k < run_len && row + k < ROWS; k++)
                claim_tile(col, row + k);
            cursor++;
        end
        // Flag the closing tile of this byte
        if (tile_expect.size() > queued_before)
        begin
            t = tile_expect.pop_back();
            t.last = 1'b1;
            tile_expect = {tile_expect, t};
        end
    endtask

    function automatic void queue_code(input logic [7:0] code, input logic start,
                                       input bit drain);
        code_req_t r;
        r.code  = code;
        r.start = start;
        r.drain = drain;
        pending_codes = {pending_codes, r};
    endfunction

    // Random code: mostly runs, some skips, a few zero bytes
    function automatic logic [7:0] random_code();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            return 8'h00;
        else if (pick < 33)
            return ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 127))
                                               : 8'($urandom_range(1, 40));
        else if (pick < 73)
            return 8'h80 | 8'($urandom_range(0, 63));
        else
            return 8'hC0 | 8'($urandom_range(0, 63));
    endfunction

    function automatic int pick_gap();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        else if (pick < 88)
            return $urandom_range(1, 3);
        else if (pick < 96)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    // Request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= 1'b0;
            codes_sent    <= 0;
            send_gap       = 0;
        end
        else
        begin
            offer = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready)
            begin
                apply_code(s_axis_tdata, s_axis_tuser);
                codes_sent <= codes_sent + 1;
                offer = 1'b0;
                // every third block of 40 requests goes out back to back
                send_gap = ((codes_sent / 40) % 3 == 1) ? 0 : pick_gap();
            end
            if (!offer)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (pending_codes.size() != 0 &&
                         (!pending_codes[0].drain || tile_expect.size() == 0))
                begin
                    next_req = pending_codes.pop_front();
                    s_axis_tdata <= next_req.code;
                    s_axis_tuser <= next_req.start;
                    offer = 1'b1;
                end
            end
            s_axis_tvalid <= offer;
        end
    end

    // Long receiver stall once the stream is well under way
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (!hold_done && codes_sent >= HOLD_AFTER)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // Result backpressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            cycle_count   <= 0;
            ready_gap      = 0;
        end
        else
        begin
            cycle_count <= cycle_count + 1;
            if (hold_left != 0)
                m_axis_tready <= 1'b0;
            else if ((cycle_count / 600) % 4 == 3)
                m_axis_tready <= 1'b1;
            else if (ready_gap > 0)
            begin
                ready_gap--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if ($urandom_range(0, 99) < 20)
                    ready_gap = ($urandom_range(0, 99) < 95) ? $urandom_range(1, 6)
                                                             : $urandom_range(15, 40);
            end
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            tiles_seen++;
            if (tile_expect.size() == 0)
                report_mismatch($sformatf("unexpected tile x=%0d y=%0d last=%0b",
                                          m_axis_tdata[4:0], m_axis_tdata[9:5],
                                          m_axis_tlast));
            else
            begin
                want_tile = tile_expect.pop_front();
                if (m_axis_tdata[4:0] !== want_tile.x)
                    report_mismatch($sformatf("tile_x %0d, want %0d (tile %0d)",
                                              m_axis_tdata[4:0], want_tile.x, tiles_seen));
                if (m_axis_tdata[9:5] !== want_tile.y)
                    report_mismatch($sformatf("tile_y %0d, want %0d (tile %0d)",
                                              m_axis_tdata[9:5], want_tile.y, tiles_seen));
                if (m_axis_tlast !== want_tile.last)
                    report_mismatch($sformatf("tlast %0b, want %0b (tile %0d)",
                                              m_axis_tlast, want_tile.last, tiles_seen));
                if (m_axis_tdata[15:10] !== '0)
                    report_mismatch($sformatf("fill bits %0h not zero (tile %0d)",
                                              m_axis_tdata[15:10], tiles_seen));
            end
        end
    end

    // Stimulus, reset and end of run
    initial
    begin
        int level_len;
        int made;
        int drain_at;
        int k;
        tiles_seen     = 0;
        map_clears     = 0;
        mismatch_count = 0;
        cursor         = 0;
        foreach (solid_rows[r])
            solid_rows[r] = '0;

        // Directed: code kinds, extremes, wrap, clip, overlap, saturated cursor
        queue_code(8'h00, 1'b1, 1'b0);   // clear with a zero byte
        queue_code(8'hBF, 1'b0, 1'b0);   // longest horizontal run, wraps a row
        queue_code(8'hFF, 1'b0, 1'b0);   // longest vertical run, clipped at bottom
        queue_code(8'h80, 1'b0, 1'b0);   // horizontal run of zero
        queue_code(8'hC0, 1'b0, 1'b0);   // vertical run of zero still steps
        queue_code(8'h7F, 1'b0, 1'b0);   // longest skip
        queue_code(8'h13, 1'b0, 1'b0);
        queue_code(8'h8F, 1'b0, 1'b0);   // crosses a solid tile and wraps
        queue_code(8'hC5, 1'b0, 1'b0);
        queue_code(8'h01, 1'b0, 1'b0);
        queue_code(8'h8A, 1'b0, 1'b0);   // plain run over clear tiles
        for (k = 0; k < 6; k++)
            queue_code(8'h7F, 1'b0, 1'b0);   // drive the cursor to the end
        queue_code(8'hBF, 1'b0, 1'b0);   // runs at the end mark nothing
        queue_code(8'hFF, 1'b0, 1'b0);
        queue_code(8'h7F, 1'b0, 1'b0);
        queue_code(8'h85, 1'b1, 1'b1);   // clear and rerun after a full drain
        queue_code(8'hFF, 1'b1, 1'b0);   // full column from the origin
        queue_code(8'hBF, 1'b0, 1'b0);
        queue_code(8'h00, 1'b0, 1'b0);

        // Random levels: a clearing byte, then a run of codes
        made = 0;
        drain_at = $urandom_range(200, 280);
        while (made < RANDOM_CODES)
        begin
            level_len = $urandom_range(6, 30);
            for (k = 0; k < level_len && made < RANDOM_CODES; k++)
            begin
                queue_code(random_code(),
                           (k == 0) ? 1'b1 : 1'($urandom_range(0, 99) < 4),
                           made == drain_at);
                made++;
            end
        end

        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_codes.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        while (tile_expect.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Applied %0d code bytes over %0d map clears, checked %0d tiles.",
                 codes_sent, map_clears, tiles_seen);
        $display("Mismatches: %0d", mismatch_count);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Watchdog
    initial
    begin
        #6_000_000;
        $display("Timed out with %0d tiles still expected.", tile_expect.size());
        $display("FAILURE");
        $finish;
    end

endmodule

// File: tile_map_rle_decoder_core.f
design/tmrle_pkg.sv
design/tmrle_ram.sv
design/tile_map_rle_decoder_core.sv
design/tmrle_checker.sv
sim/tb_top.sv
